// ===== src/pn3_pkg.sv =====
// ----------------------------------------------------------------------------
// pn3_pkg
// Shared types and the permutation table of the 3D gradient noise block.
// ----------------------------------------------------------------------------
package pn3_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned NOISE_W   = 20;
  localparam int unsigned CELL_W    = 8;
  localparam int unsigned HASH_W    = 4;
  localparam int unsigned CORNERS   = 8;
  localparam int unsigned ROM_DEPTH = 256;

  typedef struct packed {
    logic full;
    logic empty;
  } pn3_fifo_status_t;

  localparam logic [CELL_W-1:0] PERM [ROM_DEPTH] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage

// ===== src/pn3_coord_if.sv =====
// ----------------------------------------------------------------------------
// pn3_coord_if
// Valid/ready channel carrying one 3D point in signed fixed point.
// ----------------------------------------------------------------------------
interface pn3_coord_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

// ===== src/pn3_noise_if.sv =====
// ----------------------------------------------------------------------------
// pn3_noise_if
// Valid/ready channel carrying one noise value in signed Q3.16.
// ----------------------------------------------------------------------------
interface pn3_noise_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

// ===== src/pn3_front.sv =====
// ----------------------------------------------------------------------------
// pn3_front
// Splits each point into lattice cell and fraction and hashes the eight cell
// corners through the permutation table in three pipeline stages.
// ----------------------------------------------------------------------------
module pn3_front #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  output logic                                            ready_o,
  input  logic signed [pn3_pkg::COORD_W-1:0]              coord_x_i,
  input  logic signed [pn3_pkg::COORD_W-1:0]              coord_y_i,
  input  logic signed [pn3_pkg::COORD_W-1:0]              coord_z_i,
  input  pn3_pkg::pn3_fifo_status_t                       fifo_status_i,
  output logic                                            push_o,
  output logic [3*FRACTION_BITS+pn3_pkg::CORNERS*pn3_pkg::HASH_W-1:0] push_data_o
);
  import pn3_pkg::*;

  localparam int unsigned F = FRACTION_BITS;

  logic              en;
  logic              v1_q, v2_q, v3_q;
  logic [CELL_W-1:0] cx1_q, cy1_q, cz1_q;
  logic [F-1:0]      tx1_q, ty1_q, tz1_q, tx2_q, ty2_q, tz2_q, tx3_q, ty3_q, tz3_q;
  logic [CELL_W-1:0] a2_q, b2_q, cz2_q;
  logic [CELL_W-1:0] aa3_q, ab3_q, ba3_q, bb3_q;
  logic [CELL_W-1:0] hash_full [CORNERS];

  // The pipeline moves as a whole whenever its last stage can drain.
  assign en      = !v3_q || !fifo_status_i.full;
  assign ready_o = en;
  assign push_o  = v3_q && !fifo_status_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx1_q <= coord_x_i[F+CELL_W-1:F];
      cy1_q <= coord_y_i[F+CELL_W-1:F];
      cz1_q <= coord_z_i[F+CELL_W-1:F];
      tx1_q <= coord_x_i[F-1:0];
      ty1_q <= coord_y_i[F-1:0];
      tz1_q <= coord_z_i[F-1:0];

      a2_q  <= PERM[cx1_q] + cy1_q;
      b2_q  <= PERM[cx1_q + CELL_W'(1)] + cy1_q;
      cz2_q <= cz1_q;
      tx2_q <= tx1_q;
      ty2_q <= ty1_q;
      tz2_q <= tz1_q;

      aa3_q <= PERM[a2_q] + cz2_q;
      ab3_q <= PERM[a2_q + CELL_W'(1)] + cz2_q;
      ba3_q <= PERM[b2_q] + cz2_q;
      bb3_q <= PERM[b2_q + CELL_W'(1)] + cz2_q;
      tx3_q <= tx2_q;
      ty3_q <= ty2_q;
      tz3_q <= tz2_q;
    end
  end

  // Corner order: x varies fastest, then y, then z.
  always_comb begin
    hash_full[0] = PERM[aa3_q];
    hash_full[1] = PERM[ba3_q];
    hash_full[2] = PERM[ab3_q];
    hash_full[3] = PERM[bb3_q];
    hash_full[4] = PERM[aa3_q + CELL_W'(1)];
    hash_full[5] = PERM[ba3_q + CELL_W'(1)];
    hash_full[6] = PERM[ab3_q + CELL_W'(1)];
    hash_full[7] = PERM[bb3_q + CELL_W'(1)];
  end

  always_comb begin
    push_data_o = '0;
    push_data_o[3*F-1:0] = {tz3_q, ty3_q, tx3_q};
    for (int i = 0; i < CORNERS; i++) begin
      push_data_o[3*F + i*HASH_W +: HASH_W] = hash_full[i][HASH_W-1:0];
    end
  end

endmodule

// ===== src/pn3_fifo.sv =====
// ----------------------------------------------------------------------------
// pn3_fifo
// Small first-in first-out queue between the hashing and arithmetic pipelines.
// ----------------------------------------------------------------------------
module pn3_fifo #(
  parameter int unsigned WIDTH = 80
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [WIDTH-1:0]          data_i,
  input  logic                      pop_i,
  output logic [WIDTH-1:0]          data_o,
  output pn3_pkg::pn3_fifo_status_t status_o
);
  import pn3_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign status_o.full  = (count_q == (PTR_W+1)'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign data_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push_i && !pop_i) count_q <= count_q + (PTR_W+1)'(1);
      else if (pop_i && !push_i) count_q <= count_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i) else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.empty |-> !pop_i) else $error("pop from an empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W+1)'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== src/pn3_back.sv =====
// ----------------------------------------------------------------------------
// pn3_back
// Fade curves, corner gradients and trilinear blend, one point per cycle unless stalled.
// ----------------------------------------------------------------------------
module pn3_back #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  pn3_pkg::pn3_fifo_status_t                       fifo_status_i,
  output logic                                            pop_o,
  input  logic [3*FRACTION_BITS+pn3_pkg::CORNERS*pn3_pkg::HASH_W-1:0] pop_data_i,
  output logic                                            valid_o,
  input  logic                                            ready_i,
  output logic signed [pn3_pkg::NOISE_W-1:0]              noise_value_o
);
  import pn3_pkg::*;

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned W  = F + 6;
  localparam int unsigned SW = W + 17;
  localparam int unsigned NS = 8;
  localparam logic signed [W-1:0]   K_ONE  = W'(1 << F);
  localparam logic signed [W-1:0]   K_TEN  = W'(10 * (1 << F));
  localparam logic signed [W-1:0]   K_FIFT = W'(15 * (1 << F));
  localparam logic signed [2*W-1:0] HALF   = (2*W)'(1 << (F-1));
  localparam logic signed [SW-1:0]  OHALF  = SW'(1 << (F-1));
  localparam logic signed [SW-1:0]  SAT_HI = SW'(524287);
  localparam logic signed [SW-1:0]  SAT_LO = -SW'(524288);

  function automatic logic signed [W-1:0] mulr(logic signed [W-1:0] a,
                                               logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = a * b + HALF;
    return W'(p >>> F);
  endfunction

  function automatic logic signed [W-1:0] grad(logic [HASH_W-1:0] h,
                                               logic signed [W-1:0] x,
                                               logic signed [W-1:0] y,
                                               logic signed [W-1:0] z);
    logic signed [W-1:0] u, v;
    u = (h < 4'd8) ? x : y;
    if (h < 4'd4) v = y;
    else if (h == 4'd12 || h == 4'd14) v = x;
    else v = z;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic                en;
  logic [NS-1:0]       v_q;
  logic signed [W-1:0] t_in [3];
  logic signed [W-1:0] off [3][2];
  logic signed [W-1:0] g_d [CORNERS];
  logic signed [W-1:0] t_q [4][3];
  logic signed [W-1:0] p_q [4][3];
  logic signed [W-1:0] g_q [5][CORNERS];
  logic signed [W-1:0] f_q [3];
  logic signed [W-1:0] f_d [3];
  logic signed [W-1:0] lx_q [4];
  logic signed [W-1:0] fvw_q [2];
  logic signed [W-1:0] ly_q [2];
  logic signed [W-1:0] fw_q;
  logic signed [W-1:0] lz_q;
  logic signed [SW-1:0] scaled;
  logic signed [SW-1:0] shifted;

  assign en    = !valid_o || ready_i;
  assign pop_o = en && !fifo_status_i.empty;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_in[k]   = $signed({6'b0, pop_data_i[k*F +: F]});
      off[k][0] = t_in[k];
      off[k][1] = t_in[k] - K_ONE;
    end
    for (int i = 0; i < CORNERS; i++) begin
      g_d[i] = grad(pop_data_i[3*F + i*HASH_W +: HASH_W],
                    off[0][i & 1], off[1][(i >> 1) & 1], off[2][(i >> 2) & 1]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      f_d[k] = mulr(t_q[3][k], p_q[3][k]);
      if (f_d[k] < 0) f_d[k] = '0;
      else if (f_d[k] > K_ONE) f_d[k] = K_ONE;
    end
  end

  // Output rescaled to 16 fraction bits, rounded half up, then saturated.
  assign scaled  = (SW'(lz_q) <<< 16) + OHALF;
  assign shifted = scaled >>> F;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else if (en) begin
      v_q     <= {v_q[NS-2:0], pop_o};
      valid_o <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t_q[0][k] <= t_in[k];
        p_q[0][k] <= (t_in[k] <<< 2) + (t_in[k] <<< 1) - K_FIFT;
        p_q[1][k] <= mulr(t_q[0][k], p_q[0][k]) + K_TEN;
        p_q[2][k] <= mulr(t_q[1][k], p_q[1][k]);
        p_q[3][k] <= mulr(t_q[2][k], p_q[2][k]);
        for (int s = 1; s < 4; s++) t_q[s][k] <= t_q[s-1][k];
        f_q[k] <= f_d[k];
      end
      g_q[0] <= g_d;
      for (int s = 1; s < 5; s++) g_q[s] <= g_q[s-1];
      for (int j = 0; j < 4; j++) begin
        lx_q[j] <= g_q[4][2*j] + mulr(f_q[0], g_q[4][2*j+1] - g_q[4][2*j]);
      end
      fvw_q[0] <= f_q[1];
      fvw_q[1] <= f_q[2];
      for (int j = 0; j < 2; j++) begin
        ly_q[j] <= lx_q[2*j] + mulr(fvw_q[0], lx_q[2*j+1] - lx_q[2*j]);
      end
      fw_q <= fvw_q[1];
      lz_q <= ly_q[0] + mulr(fw_q, ly_q[1] - ly_q[0]);
      if (shifted > SAT_HI) noise_value_o <= NOISE_W'(SAT_HI);
      else if (shifted < SAT_LO) noise_value_o <= NOISE_W'(SAT_LO);
      else noise_value_o <= NOISE_W'(shifted);
    end
  end

endmodule

// ===== src/perlin_noise_3d.sv =====
// ----------------------------------------------------------------------------
// perlin_noise_3d
// Improved 3D gradient noise on fixed-point coordinates.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle unless its hashing pipeline is held
// by a full queue, and returns one noise value per point, in order. A point
// passes the hashing pipeline, the queue between the two halves and the
// arithmetic pipeline, whose four chained multiplications of the fade curve
// and three blending levels set its depth. Each half stalls on its own: the output
// register holds a result while new points are still accepted until the queue
// fills.
module perlin_noise_3d #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  pn3_coord_if.sink  coord_i,
  pn3_noise_if.source noise_o
);
  import pn3_pkg::*;

  localparam int unsigned QW = 3*FRACTION_BITS + CORNERS*HASH_W;

  pn3_fifo_status_t fifo_status;
  logic             push, pop;
  logic [QW-1:0]    push_data, pop_data;

  pn3_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (coord_i.valid),
    .ready_o       (coord_i.ready),
    .coord_x_i     (coord_i.coord_x),
    .coord_y_i     (coord_i.coord_y),
    .coord_z_i     (coord_i.coord_z),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  pn3_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_data),
    .pop_i    (pop),
    .data_o   (pop_data),
    .status_o (fifo_status)
  );

  pn3_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .pop_data_i    (pop_data),
    .valid_o       (noise_o.valid),
    .ready_i       (noise_o.ready),
    .noise_value_o (noise_o.noise_value)
  );

endmodule
